// ----- rtl/smoothed_four_point_delta_kernel_defines.svh -----
// ----------------------------------------------------------------------------
// Smoothed four-point delta kernel: assertion macros
// Concurrent check macros shared by the kernel RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_FOUR_POINT_DELTA_KERNEL_DEFINES_SVH
`define SMOOTHED_FOUR_POINT_DELTA_KERNEL_DEFINES_SVH
`ifndef SYNTHESIS
`define SFPDK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfpdk check failed");
`define SFPDK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfpdk check failed");
`else
`define SFPDK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SFPDK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/sfpdk_pkg.sv -----
// ----------------------------------------------------------------------------
// Smoothed four-point delta kernel package
// Internal widths, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none
package sfpdk_pkg;

  localparam int GB            = 40;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SQRT_STEPS   = GB + 2;
  localparam int CORDIC_STEPS = GB + 1;
  localparam int ROOT_W       = GB + 2;
  localparam int REM_W        = GB + 6;
  localparam int RAD_W        = GB + 4;
  localparam int XW           = GB + 4;
  localparam int ZW           = GB + 3;
  localparam int T2_W         = GB + 1;

  localparam longint ONE_G   = 64'sd1 <<< GB;
  localparam longint SQRT3_G = 64'sh1BB67AE8585;
  localparam longint PI_G    = 64'sh3243F6A8886;

  localparam logic [127:0] SP_WIDE = 128'(SQRT3_G) * 128'(PI_G);
  localparam longint SP        = longint'(SP_WIDE >> GB);
  localparam longint K_INNER   = ((64'sd17 <<< GB) / 48) + SP / 108;
  localparam longint K_OUTER   = (ONE_G / 12) - SP / 108;
  localparam longint S3_OVER12 = SQRT3_G / 12;
  localparam longint S3_OVER36 = SQRT3_G / 36;

  // Reciprocal of three, exact for values below 2^39.
  localparam longint RD3 = ((64'sd1 <<< 40) + 2) / 3;

  // atan(2^-i) at GB fractional bits, from the series at 60 bits.
  function automatic longint atan_entry(input int i);
    longint acc;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    int k;
    int m;
    acc = 0;
    if (i == 0) begin
      return PI_G >>> 2;
    end
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      num = 64'd1 << (60 - i * (2 * k + 1));
      m   = 2 * k + 1;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= 64'(m)) begin
          rem    = rem - 64'(m);
          quo[b] = 1'b1;
        end
      end
      if (k % 2 == 1) begin
        acc = acc - longint'(quo);
      end else begin
        acc = acc + longint'(quo);
      end
    end
    return (acc + (64'sd1 <<< 19)) >>> 20;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/smoothed_four_point_delta_kernel.sv -----
// ----------------------------------------------------------------------------
// Smoothed four-point delta kernel
// Weight phi(x) of the smoothed four-point immersed-boundary kernel.
// ----------------------------------------------------------------------------
// A distance is taken on every cycle in which start is high and busy is low;
// busy is high only during reset. The weight for it appears on weight with a
// one-cycle done pulse, and a new request may enter every cycle. The result
// passes through the 42-stage square-root pipeline and the 41-stage CORDIC
// pipeline, both sized by GB = 40 guard bits. The receiver cannot stall:
// results must be taken as they come.
`default_nettype none
`include "smoothed_four_point_delta_kernel_defines.svh"
module smoothed_four_point_delta_kernel #(
  parameter int FRAC_BITS = sfpdk_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [FRAC_BITS+2:0] distance,
  output logic                        done,
  output logic [FRAC_BITS-1:0]        weight
);
  import sfpdk_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SW   = GB + 6;
  localparam int S6   = GB - F - 1;
  localparam int T2SH = 2 * (GB - F);
  localparam int LAT  = 4 + SQRT_STEPS + CORDIC_STEPS + 5;
  localparam logic signed [F+4:0] UNIT_S  = (F+5)'(1) <<< F;
  localparam logic signed [F+4:0] UNIT3_S = UNIT_S + (UNIT_S <<< 1);
  localparam logic [F+2:0]  UNIT_U = (F+3)'(1) << F;
  localparam logic [F+1:0]  R3     = (F+2)'(((64'sd1 <<< (F + 2)) / 3) + 1);
  localparam logic [GB:0]   C6_1   = (GB+1)'((64'sd1 <<< S6) / 3);
  localparam logic [GB:0]   C6_2   = (GB+1)'((64'sd1 <<< (S6 + 1)) / 3);
  localparam logic [GB:0]   S3U    = (GB+1)'(SQRT3_G);
  localparam logic [37:0]   KC12   = 38'(S3_OVER12);
  localparam logic [37:0]   KC36   = 38'(S3_OVER36);
  localparam logic [38:0]   RD3U   = 39'(RD3);
  localparam logic [SW-1:0] HALF   = SW'(1) << (GB - F - 1);
  localparam logic [F+1:0]  WMAX   = (F+2)'((64'sd1 <<< F) - 1);

  typedef struct packed {
    logic                 zero;
    logic                 inner;
    logic                 neg;
    logic [F:0]           u;
    logic [T2_W-1:0]      t2;
    logic [GB:0]          tg6;
    logic signed [XW-1:0] y0;
  } info_t;

  typedef struct packed {
    info_t               info;
    logic [ROOT_W-1:0]   root;
  } post_t;

  // Stage A: request capture.
  logic              a_valid;
  logic [F+2:0]      a_dist;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_dist <= distance;
  end

  // Stage B: magnitude, region and t = 2a-1 or 2a-3.
  logic              b_valid;
  logic              b_zero;
  logic              b_inner;
  logic              b_neg;
  logic [F:0]        b_u;
  logic [F+2:0]      mag;
  logic              mag_inner;
  logic signed [F+4:0] t_full;

  always_comb begin
    mag       = a_dist[F+2] ? (~a_dist + 1'b1) : a_dist;
    mag_inner = mag <= UNIT_U;
    t_full    = $signed({2'b00, mag[F+1:0], 1'b0}) - (mag_inner ? UNIT_S : UNIT3_S);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_zero  <= mag[F+2:F+1] != 2'b00;
    b_inner <= mag_inner;
    b_neg   <= t_full[F+4];
    b_u     <= t_full[F+4] ? (F+1)'(-t_full) : (F+1)'(t_full);
  end

  // Stage C: t^2, sqrt3*t and u/3.
  logic              c_valid;
  info_t             c_info;
  logic [F:0]        c_qa;
  logic [2*F+1:0]    sq;
  logic [GB+F+1:0]   y0p;
  logic [XW-1:0]     y0m;
  logic [2*F+2:0]    qap;

  always_comb begin
    sq  = (2*F+2)'(b_u) * (2*F+2)'(b_u);
    y0p = (GB+F+2)'(S3U) * (GB+F+2)'(b_u);
    y0m = XW'(y0p >> F);
    qap = (2*F+3)'(b_u) * (2*F+3)'(R3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_info.zero  <= b_zero;
    c_info.inner <= b_inner;
    c_info.neg   <= b_neg;
    c_info.u     <= b_u;
    c_info.t2    <= T2_W'({sq, {T2SH{1'b0}}} >> GB);
    c_info.tg6   <= '0;
    c_info.y0    <= b_neg ? -$signed(y0m) : $signed(y0m);
    c_qa         <= (F+1)'(qap >> (F + 2));
  end

  // Stage D: radicand 4 - 3t^2 and |t|/6 at GB fractional bits.
  logic              d_valid;
  info_t             d_info;
  logic [RAD_W-1:0]  d_rad;
  logic [F+2:0]      rem3;

  always_comb begin
    rem3 = (F+3)'(c_info.u) - ((F+3)'(c_qa) + ((F+3)'(c_qa) << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_info.zero  <= c_info.zero;
    d_info.inner <= c_info.inner;
    d_info.neg   <= c_info.neg;
    d_info.u     <= c_info.u;
    d_info.t2    <= c_info.t2;
    d_info.y0    <= c_info.y0;
    d_info.tg6   <= ((GB+1)'(c_qa) << S6) +
                    ((rem3[1:0] == 2'd2) ? C6_2 : (rem3[1:0] == 2'd1) ? C6_1 : '0);
    d_rad        <= (RAD_W'(1) << (GB + 2)) -
                    (RAD_W'(c_info.t2) + (RAD_W'(c_info.t2) << 1));
  end

  // Square root, then angle of (r, sqrt3*t).
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  info_t             s_info;

  sfpdk_sqrt #(
    .SIDE_W($bits(info_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_rad   (d_rad),
    .in_side  (d_info),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_info)
  );

  logic                 k_valid;
  logic signed [ZW-1:0] k_z;
  post_t                k_post;
  post_t                s_post;

  assign s_post.info = s_info;
  assign s_post.root = s_root;

  sfpdk_cordic #(
    .SIDE_W($bits(post_t))
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_x     ($signed(XW'(s_root))),
    .in_y     (s_info.y0),
    .in_side  (s_post),
    .out_valid(k_valid),
    .out_z    (k_z),
    .out_side (k_post)
  );

  // Stage E: t*r and the arcsine coefficient products.
  logic               e_valid;
  info_t              e_info;
  logic               e_thneg;
  logic [F+ROOT_W:0]  e_p;
  logic [58:0]        e_ph;
  logic [58:0]        e_pl;
  logic [GB+1:0]      thm;
  logic [37:0]        kc;

  always_comb begin
    thm = k_z[ZW-1] ? (GB+2)'(-k_z) : (GB+2)'(k_z);
    kc  = k_post.info.inner ? KC12 : KC36;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_info  <= k_post.info;
    e_thneg <= k_z[ZW-1];
    e_p     <= (F+ROOT_W+1)'(k_post.info.u) * (F+ROOT_W+1)'(k_post.root);
    e_ph    <= 59'(kc) * 59'(thm[GB+1:21]);
    e_pl    <= 59'(kc) * 59'(thm[20:0]);
  end

  // Stage F: signed products back at GB fractional bits.
  logic                 f_valid;
  info_t                f_info;
  logic signed [SW-1:0] f_trs;
  logic signed [SW-1:0] f_mq;
  logic [ROOT_W-5:0]    f_v;
  logic [ROOT_W-1:0]    trm;
  logic [79:0]          thsum;
  logic [SW-1:0]        thp;

  always_comb begin
    trm   = ROOT_W'(e_p >> F);
    thsum = {e_ph, 21'b0} + 80'(e_pl);
    thp   = SW'(thsum >> GB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_info <= e_info;
    f_trs  <= e_info.neg ? -$signed(SW'(trm)) : $signed(SW'(trm));
    f_mq   <= e_thneg ? -$signed(thp) : $signed(thp);
    f_v    <= trm[ROOT_W-1:4];
  end

  // Stage G: partial sums and the divide-by-three products for t*r/48.
  logic                 g_valid;
  logic                 g_zero;
  logic                 g_inner;
  logic                 g_neg;
  logic signed [SW-1:0] g_part;
  logic [57:0]          g_qh;
  logic [57:0]          g_ql;
  logic signed [SW-1:0] t2_s;
  logic signed [SW-1:0] tg6_s;
  logic signed [SW-1:0] in_sum;
  logic signed [SW-1:0] out_sum;

  always_comb begin
    t2_s    = $signed(SW'(f_info.t2));
    tg6_s   = f_info.neg ? -$signed(SW'(f_info.tg6)) : $signed(SW'(f_info.tg6));
    in_sum  = SW'(K_INNER) + ((SW'(ONE_G) - t2_s) >>> 4) - (f_trs >>> 4) - f_mq;
    out_sum = SW'(K_OUTER) - tg6_s + (t2_s >>> 4) + f_mq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    g_zero  <= f_info.zero;
    g_inner <= f_info.inner;
    g_neg   <= f_info.neg;
    g_part  <= f_info.inner ? in_sum : out_sum;
    g_qh    <= 58'(f_v[37:19]) * 58'(RD3U);
    g_ql    <= 58'(f_v[18:0]) * 58'(RD3U);
  end

  // Stage H: final sum.
  logic                 h_valid;
  logic                 h_zero;
  logic signed [SW-1:0] h_sum;
  logic [76:0]          q48w;
  logic [SW-1:0]        q48;
  logic signed [SW-1:0] tr48;

  always_comb begin
    q48w = {g_qh, 19'b0} + 77'(g_ql);
    q48  = SW'(q48w >> 40);
    tr48 = g_neg ? -$signed(q48) : $signed(q48);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    h_zero <= g_zero;
    h_sum  <= g_inner ? g_part : g_part + tr48;
  end

  // Stage I: clamp, round half up and present the result.
  logic [SW-1:0] sum_pos;
  logic [F+1:0]  w_round;

  always_comb begin
    sum_pos = h_sum[SW-1] ? '0 : $unsigned(h_sum);
    w_round = (F+2)'((sum_pos + HALF) >> (GB - F));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_zero) begin
      weight <= '0;
    end else if (w_round > WMAX) begin
      weight <= F'(WMAX);
    end else begin
      weight <= F'(w_round);
    end
  end

  // A request whose positive distance is two or more.
  logic far_req;

  assign far_req = start && !busy && (distance[F+2:F+1] == 2'b01);

  `SFPDK_ASSERT_IMPLY(a_done_has_request, clk, rst, done, $past(start && !busy, LAT))
  `SFPDK_ASSERT_IMPLY(a_far_is_zero, clk, rst, done && $past(far_req, LAT), weight == '0)
  `SFPDK_ASSERT_IMPLY(a_weight_below_peak, clk, rst, done, !(weight[F-1] && weight[F-2]))
  `SFPDK_ASSERT_NEXT(a_last_stage_feeds_done, clk, rst, h_valid, done)

endmodule
`default_nettype wire

// ----- rtl/sfpdk_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined square root
// floor(sqrt(d * 2^GB)), one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sfpdk_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sfpdk_pkg::RAD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [sfpdk_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]             out_side
);
  import sfpdk_pkg::*;

  // Radicand bits are consumed only while the pair index reaches into d.
  localparam int RAD_STAGES = SQRT_STEPS - GB / 2;

  logic              v_q    [0:SQRT_STEPS];
  logic [REM_W-1:0]  rem_q  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [0:SQRT_STEPS];
  logic [SIDE_W-1:0] side_q [0:SQRT_STEPS];
  logic [RAD_W-1:0]  rad_q  [0:RAD_STAGES-1];

  assign v_q[0]    = in_valid;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = in_side;
  assign rad_q[0]  = in_rad;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam int P  = SQRT_STEPS - 1 - s;
    localparam int SH = 2 * P - GB;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (SH >= 0) begin : g_pair
      assign pair = rad_q[s][SH+1:SH];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_q[s][REM_W-3:0], pair};
    assign trial  = REM_W'({root_q[s], 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk) begin
      side_q[s+1] <= side_q[s];
      if (rem_sh >= trial) begin
        rem_q[s+1]  <= rem_sh - trial;
        root_q[s+1] <= {root_q[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[s+1]  <= rem_sh;
        root_q[s+1] <= {root_q[s][ROOT_W-2:0], 1'b0};
      end
    end

    if (s + 1 < RAD_STAGES) begin : g_rad
      always_ff @(posedge clk) begin
        rad_q[s+1] <= rad_q[s];
      end
    end
  end

  assign out_valid = v_q[SQRT_STEPS];
  assign out_root  = root_q[SQRT_STEPS];
  assign out_side  = side_q[SQRT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/sfpdk_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring
// Angle of (x, y) with x > 0, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sfpdk_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [sfpdk_pkg::XW-1:0] in_x,
  input  logic signed [sfpdk_pkg::XW-1:0] in_y,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic signed [sfpdk_pkg::ZW-1:0] out_z,
  output logic [SIDE_W-1:0]               out_side
);
  import sfpdk_pkg::*;

  logic                 v_q    [0:CORDIC_STEPS];
  logic signed [XW-1:0] x_q    [0:CORDIC_STEPS-1];
  logic signed [XW-1:0] y_q    [0:CORDIC_STEPS-1];
  logic signed [ZW-1:0] z_q    [0:CORDIC_STEPS];
  logic [SIDE_W-1:0]    side_q [0:CORDIC_STEPS];

  assign v_q[0]    = in_valid;
  assign x_q[0]    = in_x;
  assign y_q[0]    = in_y;
  assign z_q[0]    = '0;
  assign side_q[0] = in_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_entry(i));
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      side_q[i+1] <= side_q[i];
      if (y_q[i][XW-1]) begin
        z_q[i+1] <= z_q[i] - ANG;
      end else begin
        z_q[i+1] <= z_q[i] + ANG;
      end
    end

    if (i + 1 < CORDIC_STEPS) begin : g_xy
      always_ff @(posedge clk) begin
        if (y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
        end
      end
    end
  end

  assign out_valid = v_q[CORDIC_STEPS];
  assign out_z     = z_q[CORDIC_STEPS];
  assign out_side  = side_q[CORDIC_STEPS];

endmodule
`default_nettype wire
